[hw/rtl/sps_pkg.sv]
// Package: shared types, opcodes and status codes for the sparse pointer stack.
package sps_pkg;
	localparam int DEPTH_DEF = 256;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		OP_PUSH = 4'd0, OP_POP = 4'd1, OP_PEEK = 4'd2, OP_RD_BOT = 4'd3,
		OP_RD_TOP = 4'd4, OP_ASSIGN = 4'd5, OP_ASSIGN_EMPTY = 4'd6,
		OP_REMOVE = 4'd7, OP_INSERT = 4'd8, OP_INSERT_TOP = 4'd9
	} opcode_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [31:0] entry_value;
		logic [7:0]  position;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic [7:0]  slot_index;
		logic [8:0]  entry_count;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_BAD, CMD_OP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  opcode;
		logic [31:0] entry_value;
		logic [7:0]  position;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_RD_WAIT, S_RD_DONE, S_PAD, S_SHIFT_RD, S_SHIFT_WR,
		S_SCAN_RD, S_SCAN_CHK, S_TRIM_RD, S_TRIM_CHK, S_OUT
	} exec_state_t;
endpackage

[hw/rtl/sps_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module sps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/sps_front.sv]
// Front end: accept input items, classify them and queue commands.
module sps_front import sps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);
	localparam int QW = $clog2(QUEUE_DEPTH);
	cmd_t q_q [QUEUE_DEPTH];
	logic [QW-1:0] wp_q, rp_q;
	logic [QW:0] cnt_q;
	cmd_t c;
	logic push, pop;

	always_comb begin
		c.opcode = in_item.opcode;
		c.entry_value = in_item.entry_value;
		c.position = in_item.position;
		c.kind = (in_item.opcode <= 4'd9) ? CMD_OP : CMD_BAD;
	end

	assign in_ready = (cnt_q != (QW+1)'(QUEUE_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd = q_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end
endmodule

[hw/rtl/sps_back.sv]
// Back end: execute stack commands against the entry RAM.
module sps_back import sps_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

	exec_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [CW-1:0] cnt_q, cnt_d, k_q, k_d, tgt_q, tgt_d;
	out_item_t res_q, res_d;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;
	logic [CW-1:0] pos_w;

	sps_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign pos_w = CW'(cmd_q.position);
	assign cmd_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_item = res_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		k_d = k_q;
		tgt_d = tgt_q;
		res_d = res_q;
		we = 1'b0;
		waddr = k_q[AW-1:0];
		wdata = '0;
		raddr = k_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				res_d = '0;
				state_d = S_OUT;
				if (cmd_q.kind == CMD_BAD) begin
					res_d.status = ST_RANGE;
				end else begin
					case (cmd_q.opcode)
						OP_PUSH: begin
							if (cnt_q >= CW'(DEPTH)) res_d.status = ST_FULL;
							else begin
								we = 1'b1; waddr = cnt_q[AW-1:0];
								wdata = cmd_q.entry_value; cnt_d = cnt_q + 1'b1;
							end
						end
						OP_POP, OP_PEEK: begin
							if (cnt_q == '0) res_d.status = ST_RANGE;
							else begin
								k_d = cnt_q - 1'b1; state_d = S_RD_WAIT;
								if (cmd_q.opcode == OP_POP) cnt_d = cnt_q - 1'b1;
							end
						end
						OP_RD_BOT, OP_RD_TOP, OP_REMOVE: begin
							if (pos_w >= cnt_q) res_d.status = ST_RANGE;
							else begin
								k_d = (cmd_q.opcode == OP_RD_TOP) ? cnt_q - 1'b1 - pos_w : pos_w;
								state_d = S_RD_WAIT;
							end
						end
						OP_ASSIGN: begin
							if (pos_w >= CW'(DEPTH)) res_d.status = ST_FULL;
							else begin
								tgt_d = pos_w; k_d = cnt_q; state_d = S_PAD;
							end
						end
						OP_ASSIGN_EMPTY: begin
							k_d = '0; state_d = S_SCAN_RD;
						end
						OP_INSERT, OP_INSERT_TOP: begin
							if (pos_w > cnt_q) res_d.status = ST_RANGE;
							else if (cnt_q >= CW'(DEPTH)) res_d.status = ST_FULL;
							else begin
								tgt_d = (cmd_q.opcode == OP_INSERT) ? pos_w : cnt_q - pos_w;
								k_d = cnt_q; state_d = S_SHIFT_RD;
							end
						end
						default: res_d.status = ST_RANGE;
					endcase
				end
			end
			S_RD_WAIT: state_d = S_RD_DONE;
			S_RD_DONE: begin
				res_d.read_value = rdata;
				if (cmd_q.opcode == OP_REMOVE) begin
					we = 1'b1; waddr = k_q[AW-1:0]; wdata = '0;
					state_d = S_TRIM_RD;
				end else state_d = S_OUT;
			end
			S_TRIM_RD: begin
				if (cnt_q == '0) state_d = S_OUT;
				else begin
					raddr = AW'(cnt_q - 1'b1); state_d = S_TRIM_CHK;
				end
			end
			S_TRIM_CHK: begin
				raddr = AW'(cnt_q - 1'b1);
				if (rdata == '0) begin
					cnt_d = cnt_q - 1'b1; state_d = S_TRIM_RD;
				end else state_d = S_OUT;
			end
			S_PAD: begin
				we = 1'b1; waddr = k_q[AW-1:0];
				if (k_q >= tgt_q) begin
					waddr = tgt_q[AW-1:0]; wdata = cmd_q.entry_value;
					if (tgt_q >= cnt_q) cnt_d = tgt_q + 1'b1;
					if (cmd_q.opcode == OP_ASSIGN_EMPTY) res_d.slot_index = tgt_q[7:0];
					state_d = S_OUT;
				end else k_d = k_q + 1'b1;
			end
			S_SCAN_RD: begin
				if (k_q >= cnt_q) begin
					if (k_q >= CW'(DEPTH)) begin
						res_d.status = ST_FULL; state_d = S_OUT;
					end else begin
						tgt_d = k_q; k_d = cnt_q; state_d = S_PAD;
					end
				end else state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (rdata == '0) begin
					tgt_d = k_q; k_d = cnt_q; state_d = S_PAD;
				end else begin
					k_d = k_q + 1'b1; state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				if (k_q <= tgt_q) begin
					we = 1'b1; waddr = tgt_q[AW-1:0]; wdata = cmd_q.entry_value;
					cnt_d = cnt_q + 1'b1; state_d = S_OUT;
				end else begin
					raddr = AW'(k_q - 1'b1); state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				we = 1'b1; waddr = k_q[AW-1:0]; wdata = rdata;
				k_d = k_q - 1'b1; state_d = S_SHIFT_RD;
			end
			S_OUT: begin
				res_d.entry_count = 9'(cnt_q);
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (state_d == S_OUT) res_d.entry_count = 9'(cnt_d);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) cmd_q <= cmd;
		res_q <= res_d;
		k_q <= k_d;
		tgt_q <= tgt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end
endmodule

[hw/rtl/sparse_pointer_stack.sv]
// Top level: sparse pointer stack, front classifier and back executor.
//  channel | valid    | ready    | payload
//  in      | in_valid | in_ready | in_item  (in_item_t)
//  out     | out_valid| out_ready| out_item (out_item_t)
// Pops, peeks and reads wait on the registered RAM read; remove then clears the entry and
// trims zero entries off the top of the stack.
// Assign pads one entry a cycle; scan, shift and trim each use a read state and a check
// or write state per entry.
// Reset clears the count and the queue; the entry RAM is not cleared.
// The two-entry queue lets the front take items while the back stalls on out_ready.
module sparse_pointer_stack import sps_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	sps_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	sps_back #(.DEPTH(DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule
